### rtl/lpr_pkg.sv
// Shared types and constants for the linear parameter ramp block.
// Used by the stream interfaces, the serial divider and the top level.
package lpr_pkg;

	localparam int FRAME_BITS    = 16;
	localparam int VALUE_BITS    = 32;
	localparam int DIVIDEND_BITS = VALUE_BITS + 1;
	localparam int CNT_BITS      = $clog2(DIVIDEND_BITS + 1);

	// Command codes carried by an input item
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	// 1.0 in Q16.16
	localparam logic signed [VALUE_BITS-1:0] VALUE_ONE = VALUE_BITS'(65536);

	typedef struct packed {
		logic                     start;
		logic                     negative;
		logic [DIVIDEND_BITS-1:0] magnitude;
		logic [FRAME_BITS-1:0]    divisor;
	} div_req_t;

	typedef struct packed {
		logic                            done;
		logic signed [DIVIDEND_BITS-1:0] quotient;
	} div_rsp_t;

endpackage

### rtl/lpr_cmd_if.sv
// Input channel of the ramp block: valid/ready plus the command item.
// Depends on lpr_pkg for field widths.
interface lpr_cmd_if import lpr_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic                         command;
	logic signed [VALUE_BITS-1:0] target_value;
	logic [FRAME_BITS-1:0]        frame_count;

	modport source(output valid, command, target_value, frame_count, input ready);
	modport sink(input valid, command, target_value, frame_count, output ready);
endinterface

### rtl/lpr_res_if.sv
// Output channel of the ramp block: valid/ready plus the result item.
// Depends on lpr_pkg for field widths.
interface lpr_res_if import lpr_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] current_value;
	logic                         ongoing;

	modport source(output valid, current_value, ongoing, input ready);
	modport sink(input valid, current_value, ongoing, output ready);
endinterface

### rtl/linear_parameter_ramp_top.sv
// Linear parameter ramp: a start item sets a target and a frame count, each tick steps the value.
// Items are taken when the result slot is free or draining; a start with a nonzero count then holds
// off further items while the bit-serial divider produces 33 quotient bits, fixes the sign and hands back the step.
// A tick result is loaded into the output register in the cycle after the tick is taken.
// Reset (arst_n, asynchronous, active low): value, target and step to 1.0, no frames left.
// Depends on lpr_pkg, lpr_cmd_if, lpr_res_if and lpr_divider.
module linear_parameter_ramp_top import lpr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	lpr_cmd_if.sink    cmd,
	lpr_res_if.source  res
);

	typedef enum logic [1:0] {
		RAMP_IDLE = 2'b01,
		RAMP_DIV  = 2'b10
	} ramp_state_t;

	ramp_state_t                     state_q;
	logic [FRAME_BITS-1:0]           frames_left_q;
	logic signed [VALUE_BITS-1:0]    goal_value_q;
	logic signed [VALUE_BITS-1:0]    present_value_q;
	logic signed [DIVIDEND_BITS-1:0] step_size_q;

	logic                            out_valid_q;
	logic signed [VALUE_BITS-1:0]    out_value_q;
	logic                            out_ongoing_q;

	logic                            accept;
	logic                            is_start;
	logic                            is_tick;
	logic [FRAME_BITS-1:0]           frames_next;
	logic signed [VALUE_BITS+1:0]    stepped;
	logic                            overflow;
	logic signed [VALUE_BITS-1:0]    stepped_sat;
	logic signed [VALUE_BITS-1:0]    tick_value;
	logic signed [DIVIDEND_BITS-1:0] span_down;
	logic signed [DIVIDEND_BITS-1:0] span_up;
	div_req_t                        div_req;
	div_rsp_t                        div_rsp;

	// Take an item only between divisions and when the result slot is free or draining
	assign cmd.ready = (state_q == RAMP_IDLE) && (!out_valid_q || res.ready);
	assign accept    = cmd.valid && cmd.ready;
	assign is_start  = accept && (cmd.command == CMD_START);
	assign is_tick   = accept && (cmd.command == CMD_TICK);

	// Tick datapath: subtract the step from the value and saturate to the signed value range
	assign frames_next = frames_left_q - FRAME_BITS'(1);
	assign stepped     = (VALUE_BITS+2)'(present_value_q) - (VALUE_BITS+2)'(step_size_q);
	assign overflow    = (stepped[VALUE_BITS+1] != stepped[VALUE_BITS])
	                  || (stepped[VALUE_BITS+1] != stepped[VALUE_BITS-1]);

	always_comb begin
		if (!overflow) begin
			stepped_sat = stepped[VALUE_BITS-1:0];
		end else if (stepped[VALUE_BITS+1]) begin
			stepped_sat = {1'b1, {(VALUE_BITS-1){1'b0}}};
		end else begin
			stepped_sat = {1'b0, {(VALUE_BITS-1){1'b1}}};
		end
	end

	// Land exactly on the target on the last frame
	assign tick_value = (frames_next != '0) ? stepped_sat : goal_value_q;

	// Start datapath: both signs of the span in parallel, pick the magnitude
	assign span_down = DIVIDEND_BITS'(present_value_q) - DIVIDEND_BITS'(cmd.target_value);
	assign span_up   = DIVIDEND_BITS'(cmd.target_value) - DIVIDEND_BITS'(present_value_q);

	assign div_req.start     = is_start && (cmd.frame_count != '0);
	assign div_req.negative  = span_down[DIVIDEND_BITS-1];
	assign div_req.magnitude = span_down[DIVIDEND_BITS-1] ? span_up : span_down;
	assign div_req.divisor   = cmd.frame_count;

	lpr_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Sequencer: hold off new items while the divider runs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RAMP_IDLE;
		end else begin
			case (state_q)
				RAMP_IDLE: begin
					if (div_req.start) begin
						state_q <= RAMP_DIV;
					end
				end
				RAMP_DIV: begin
					if (div_rsp.done) begin
						state_q <= RAMP_IDLE;
					end
				end
				default: begin
					state_q <= RAMP_IDLE;
				end
			endcase
		end
	end

	// Ramp state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_left_q   <= '0;
			goal_value_q    <= VALUE_ONE;
			present_value_q <= VALUE_ONE;
			step_size_q     <= DIVIDEND_BITS'(VALUE_ONE);
		end else begin
			if (is_start) begin
				goal_value_q  <= cmd.target_value;
				frames_left_q <= cmd.frame_count;
				if (cmd.frame_count == '0) begin
					present_value_q <= cmd.target_value;
				end
			end else if (is_tick && (frames_left_q != '0)) begin
				frames_left_q   <= frames_next;
				present_value_q <= tick_value;
			end
			if (div_rsp.done) begin
				step_size_q <= div_rsp.quotient;
			end
		end
	end

	// Output register: load on a tick, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (is_tick) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (is_tick) begin
			out_ongoing_q <= (frames_left_q != '0);
			out_value_q   <= (frames_left_q != '0) ? tick_value : present_value_q;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.current_value = out_value_q;
	assign res.ongoing       = out_ongoing_q;

endmodule

### rtl/lpr_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle, then a sign fix.
// Depends on lpr_pkg for the request and response structs.
module lpr_divider import lpr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	typedef enum logic [2:0] {
		DIV_IDLE = 3'b001,
		DIV_RUN  = 3'b010,
		DIV_SIGN = 3'b100
	} div_state_t;

	div_state_t                 state_q;
	logic [CNT_BITS-1:0]        count_q;
	logic [DIVIDEND_BITS-1:0]   quo_q;
	logic [FRAME_BITS-1:0]      rem_q;
	logic [FRAME_BITS-1:0]      divisor_q;
	logic                       negative_q;
	logic                       done_q;
	logic [FRAME_BITS:0]        trial;
	logic                       fits;

	// Shift the next dividend bit into the partial remainder and try the subtract
	assign trial = {rem_q, quo_q[DIVIDEND_BITS-1]} - {1'b0, divisor_q};
	assign fits  = ~trial[FRAME_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				DIV_IDLE: begin
					if (req.start) begin
						count_q <= CNT_BITS'(DIVIDEND_BITS);
						state_q <= DIV_RUN;
					end
				end
				DIV_RUN: begin
					count_q <= count_q - CNT_BITS'(1);
					if (count_q == CNT_BITS'(1)) begin
						state_q <= DIV_SIGN;
					end
				end
				DIV_SIGN: begin
					done_q  <= 1'b1;
					state_q <= DIV_IDLE;
				end
				default: begin
					state_q <= DIV_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			DIV_IDLE: begin
				if (req.start) begin
					quo_q      <= req.magnitude;
					rem_q      <= '0;
					divisor_q  <= req.divisor;
					negative_q <= req.negative;
				end
			end
			DIV_RUN: begin
				rem_q <= fits ? trial[FRAME_BITS-1:0]
				              : {rem_q[FRAME_BITS-2:0], quo_q[DIVIDEND_BITS-1]};
				quo_q <= {quo_q[DIVIDEND_BITS-2:0], fits};
			end
			DIV_SIGN: begin
				if (negative_q) begin
					quo_q <= -quo_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = signed'(quo_q);

endmodule
